>>> design/minv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package minv_pkg;

    localparam int FIELD_W = 64;
    localparam int WIDTH   = 64;
    localparam int SHIFT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_INVERSE = 2'd1,
        STATUS_ZERO       = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CORE_IDLE,
        CORE_UP,
        CORE_DOWN,
        CORE_FIN,
        CORE_DONE
    } core_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        status_t          status;
    } core_res_t;

endpackage

`default_nettype wire

>>> design/modular_inverse.sv
// Modular inverse by the extended Euclidean algorithm. Each input beat
// carries value and modulus; one result beat returns the inverse of value
// modulo modulus in 0..modulus-1 with status 0 (ok), 1 (gcd not one, inverse
// 0) or 2 (value or modulus zero, inverse 0). Each quotient is found by a
// single shared shift/compare/subtract unit: the divisor is shifted up to
// align, then subtracted back down bit by bit, over the value reduction
// and every Euclid step, with setup before and sign correction and
// hand-off after; a zero operand goes straight to hand-off. s_ready is
// high only while no item is in the unit; the result register lets the
// next item start while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse
    import minv_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [FIELD_W-1:0] s_value,
    input  wire logic [FIELD_W-1:0] s_modulus,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [FIELD_W-1:0]      m_inverse,
    output logic [1:0]              m_status
);

    core_stat_t         core_stat;
    core_res_t          core_res;
    logic               start;
    logic               take;
    logic               m_valid_reg, m_valid_next;
    logic [WIDTH-1:0]   inv_reg, inv_next;
    status_t            status_reg, status_next;

    assign s_ready = core_stat.idle;
    assign start   = s_valid && s_ready;
    assign take    = core_stat.done && (!m_valid_reg || m_ready);

    minv_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .value   (s_value[WIDTH-1:0]),
        .modulus (s_modulus[WIDTH-1:0]),
        .take    (take),
        .stat    (core_stat),
        .res     (core_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        inv_next     = inv_reg;
        status_next  = status_reg;
        if (take) begin
            m_valid_next = 1'b1;
            inv_next     = core_res.inverse;
            status_next  = core_res.status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inv_reg    <= inv_next;
        status_reg <= status_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_inverse = FIELD_W'(inv_reg);
    assign m_status  = status_reg;

endmodule

`default_nettype wire

>>> design/minv_core.sv
`timescale 1ns / 1ps
`default_nettype none

module minv_core
    import minv_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] value,
    input  wire logic [WIDTH-1:0] modulus,
    input  wire logic             take,
    output core_stat_t            stat,
    output core_res_t             res
);

    core_state_t        state_reg, state_next;
    logic [WIDTH-1:0]   rem_reg, rem_next;
    logic [WIDTH-1:0]   div_reg, div_next;
    logic [WIDTH-1:0]   base_reg, base_next;
    logic [WIDTH-1:0]   mod_reg, mod_next;
    logic [WIDTH-1:0]   sacc_reg, sacc_next;
    logic [WIDTH-1:0]   t_reg, t_next;
    logic [WIDTH-1:0]   sbase_reg, sbase_next;
    logic               neg0_reg, neg0_next;
    logic               neg1_reg, neg1_next;
    logic [SHIFT_W-1:0] k_reg, k_next;
    logic [WIDTH-1:0]   inv_reg, inv_next;
    status_t            status_reg, status_next;

    logic [WIDTH-1:0]   div_dbl;
    logic               up_ok;
    logic               sub_ok;
    logic [WIDTH-1:0]   rem_sub;
    logic [WIDTH-1:0]   sacc_add;
    logic [WIDTH-1:0]   s_red;
    logic [WIDTH-1:0]   s_neg;

    assign div_dbl  = {div_reg[WIDTH-2:0], 1'b0};
    assign up_ok    = !div_reg[WIDTH-1] && (div_dbl <= rem_reg);
    assign sub_ok   = div_reg <= rem_reg;
    assign rem_sub  = sub_ok ? (rem_reg - div_reg) : rem_reg;
    assign sacc_add = sub_ok ? (sacc_reg + t_reg) : sacc_reg;
    assign s_red    = (sacc_reg >= mod_reg) ? '0 : sacc_reg;
    assign s_neg    = mod_reg - s_red;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CORE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        base_reg   <= base_next;
        mod_reg    <= mod_next;
        sacc_reg   <= sacc_next;
        t_reg      <= t_next;
        sbase_reg  <= sbase_next;
        neg0_reg   <= neg0_next;
        neg1_reg   <= neg1_next;
        k_reg      <= k_next;
        inv_reg    <= inv_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        base_next   = base_reg;
        mod_next    = mod_reg;
        sacc_next   = sacc_reg;
        t_next      = t_reg;
        sbase_next  = sbase_reg;
        neg0_next   = neg0_reg;
        neg1_next   = neg1_reg;
        k_next      = k_reg;
        inv_next    = inv_reg;
        status_next = status_reg;
        case (state_reg)
            CORE_IDLE: begin
                if (start) begin
                    if (value == '0 || modulus == '0) begin
                        inv_next    = '0;
                        status_next = STATUS_ZERO;
                        state_next  = CORE_DONE;
                    end else begin
                        // reduce value mod modulus as a first division step
                        rem_next   = value;
                        div_next   = modulus;
                        base_next  = modulus;
                        mod_next   = modulus;
                        sacc_next  = {{(WIDTH-1){1'b0}}, 1'b1};
                        t_next     = '0;
                        sbase_next = '0;
                        neg0_next  = 1'b0;
                        neg1_next  = 1'b1;
                        k_next     = '0;
                        state_next = CORE_UP;
                    end
                end
            end
            CORE_UP: begin
                if (up_ok) begin
                    div_next = div_dbl;
                    t_next   = {t_reg[WIDTH-2:0], 1'b0};
                    k_next   = k_reg + 1'b1;
                end else begin
                    state_next = CORE_DOWN;
                end
            end
            CORE_DOWN: begin
                if (k_reg == '0) begin
                    // rotate remainders and coefficients for the next quotient
                    rem_next   = base_reg;
                    base_next  = rem_sub;
                    div_next   = rem_sub;
                    sacc_next  = sbase_reg;
                    sbase_next = sacc_add;
                    t_next     = sacc_add;
                    neg0_next  = neg1_reg;
                    neg1_next  = !neg1_reg;
                    state_next = (rem_sub == '0) ? CORE_FIN : CORE_UP;
                end else begin
                    rem_next  = rem_sub;
                    sacc_next = sacc_add;
                    div_next  = {1'b0, div_reg[WIDTH-1:1]};
                    t_next    = {1'b0, t_reg[WIDTH-1:1]};
                    k_next    = k_reg - 1'b1;
                end
            end
            CORE_FIN: begin
                if (rem_reg != {{(WIDTH-1){1'b0}}, 1'b1}) begin
                    inv_next    = '0;
                    status_next = STATUS_NO_INVERSE;
                end else begin
                    inv_next    = (neg0_reg && s_red != '0) ? s_neg : s_red;
                    status_next = STATUS_OK;
                end
                state_next = CORE_DONE;
            end
            CORE_DONE: begin
                if (take) begin
                    state_next = CORE_IDLE;
                end
            end
            default: begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    assign stat.idle   = (state_reg == CORE_IDLE);
    assign stat.done   = (state_reg == CORE_DONE);
    assign res.inverse = inv_reg;
    assign res.status  = status_reg;

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CORE_DONE && !take) |=>
            (state_reg == CORE_DONE && $stable(inv_reg) && $stable(status_reg)))
        else $error("result changed while waiting");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CORE_DONE && status_reg != STATUS_OK) |-> (inv_reg == '0))
        else $error("nonzero inverse with failing status");

    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CORE_DONE && status_reg == STATUS_OK) |-> (inv_reg < mod_reg))
        else $error("inverse not below modulus");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CORE_IDLE && start) |=> (state_reg == CORE_UP || state_reg == CORE_DONE))
        else $error("start did not launch");

endmodule

`default_nettype wire
